[rtl/lcpsb_pkg.sv]
// Package for the LSB-first code packer with sub-block lengths.
// Holds the action and result-kind codes, the result record and the size limits.
// Has no dependencies; the top level and the checker import it.
package lcpsb_pkg;

  // Sub-block size and code-length limit.
  localparam int BLOCK_BYTES   = 255;
  localparam int MAX_CODE_BITS = 16;

  // Effective sub-block length, held to the range 2 to 255.
  localparam int SUB_LEN_INT = (BLOCK_BYTES < 2) ? 2 :
                               ((BLOCK_BYTES > 255) ? 255 : BLOCK_BYTES);
  // Effective code-length limit, never above the 16-bit code field.
  localparam int CODE_LIMIT_INT = (MAX_CODE_BITS < 16) ? MAX_CODE_BITS : 16;

  localparam logic [7:0] SUB_LEN    = 8'(SUB_LEN_INT);
  localparam logic [4:0] CODE_LIMIT = 5'(CODE_LIMIT_INT);

  // Input action codes.
  typedef enum logic {
    ACT_APPEND = 1'b0,
    ACT_FLUSH  = 1'b1
  } action_e;

  // Result kind codes.
  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_LEN  = 1'b1
  } kind_e;

  // One result beat.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic       last;
  } result_t;

  localparam result_t RESULT_NONE = '{kind: KIND_DATA, out_byte: 8'h00, last: 1'b0};

endpackage

[rtl/lsb_first_code_packer_subblocks_unit.sv]
// Top level of the LSB-first code packer with sub-block lengths.
// Depends on lcpsb_pkg for codes, the result record and the size limits.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per beat: an
//   append of code_bits_i low bits of code_value_i, or a flush. Output channel
//   (out_valid_o / out_stall_i) carries one result per beat: a packed data
//   byte (kind 0) or a sub-block length (kind 1); last_o marks the final
//   result caused by an item. An item causes zero to three results.
//   An accepted item is held in the input register, then its results are
//   loaded into the result buffer, whose entry 0 is offered.
//   Throughput: one item per cycle while each item causes at most one result
//   and the receiver does not stall; otherwise one result per cycle while
//   not stalled, set by the three-entry result buffer that drains through the
//   single output port; the next item moves on only as the last result drains.
//   The packing state (partial byte, pending bit count, sub-block position)
//   is updated as an item moves from the input register into the buffer.
//   Reset clears the packing state and empties the input register and the buffer.
//   When the receiver stalls, the offered result holds, the buffer keeps its results and
//   in_stall_o rises once the input register cannot move on.
module lsb_first_code_packer_subblocks_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [15:0] code_value_i,
  input  logic [4:0]  code_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);
  import lcpsb_pkg::*;

  // Input register.
  logic        s1_valid_q;
  action_e     s1_action_q;
  logic [15:0] s1_value_q;
  logic [4:0]  s1_bits_q;

  // Packing state.
  logic [7:0] partial_q, partial_d;
  logic [2:0] pend_q, pend_d;
  logic [7:0] pos_q, pos_d;

  // Result buffer; entry 0 is the one offered.
  result_t    buf_q [3];
  logic [1:0] cnt_q;

  // Result build signals.
  result_t     res [3];
  logic [1:0]  n;
  logic [4:0]  nb;
  logic [15:0] value_m;
  logic [23:0] acc;
  logic [4:0]  total;
  logic [1:0]  nd;
  logic [7:0]  dbyte [2];
  logic [8:0]  pos_inc;

  logic in_take, out_take, s1_move;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_take    = out_valid_o && !out_stall_i;
  assign s1_move     = s1_valid_q && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_take));
  assign in_stall_o  = s1_valid_q && !s1_move;
  assign in_take     = in_valid_i && !in_stall_o;

  assign kind_o     = buf_q[0].kind;
  assign out_byte_o = buf_q[0].out_byte;
  assign last_o     = buf_q[0].last;

  // Input register: control is reset, payload is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_action_q <= action_e'(action_i);
      s1_value_q  <= code_value_i;
      s1_bits_q   <= code_bits_i;
    end
  end

  // Merge the code into the partial byte and list the results it causes.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res[i] = RESULT_NONE;
    end
    n         = 2'd0;
    pos_d     = pos_q;
    partial_d = partial_q;
    pend_d    = pend_q;
    pos_inc   = 9'd0;

    nb      = (s1_bits_q > CODE_LIMIT) ? CODE_LIMIT : s1_bits_q;
    value_m = s1_value_q & ~(16'hFFFF << nb);
    acc     = {16'h0000, partial_q} | ({8'h00, value_m} << pend_q);
    total   = {2'b00, pend_q} + nb;

    // Whole bytes ready for output.
    if (s1_action_q == ACT_APPEND) begin
      nd       = total[4:3];
      dbyte[0] = acc[7:0];
      dbyte[1] = acc[15:8];
      case (total[4:3])
        2'd0:    partial_d = acc[7:0];
        2'd1:    partial_d = acc[15:8];
        default: partial_d = acc[23:16];
      endcase
      pend_d = total[2:0];
    end else begin
      nd       = (pend_q != 3'd0) ? 2'd1 : 2'd0;
      dbyte[0] = partial_q;
      dbyte[1] = 8'h00;
    end

    // Data bytes, each followed by a length beat when it fills a sub-block.
    for (int j = 0; j < 2; j++) begin
      if (2'(j) < nd) begin
        res[n] = '{kind: KIND_DATA, out_byte: dbyte[j], last: 1'b0};
        n      = n + 2'd1;
        pos_inc = {1'b0, pos_d} + 9'd1;
        if (pos_inc >= {1'b0, SUB_LEN}) begin
          res[n] = '{kind: KIND_LEN, out_byte: SUB_LEN, last: 1'b0};
          n      = n + 2'd1;
          pos_d  = 8'h00;
        end else begin
          pos_d = pos_inc[7:0];
        end
      end
    end

    // A flush closes the last sub-block and clears the state.
    if (s1_action_q == ACT_FLUSH) begin
      res[n]    = '{kind: KIND_LEN, out_byte: pos_d, last: 1'b0};
      n         = n + 2'd1;
      pos_d     = 8'h00;
      partial_d = 8'h00;
      pend_d    = 3'd0;
    end

    if (n != 2'd0) begin
      res[n - 2'd1].last = 1'b1;
    end
  end

  // Packing state advances as an item leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= 8'h00;
      pend_q    <= 3'd0;
      pos_q     <= 8'h00;
    end else if (s1_move) begin
      partial_q <= partial_d;
      pend_q    <= pend_d;
      pos_q     <= pos_d;
    end
  end

  // Result buffer count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (s1_move) begin
      cnt_q <= n;
    end else if (out_take) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // Result buffer entries: load a new list or shift one beat out.
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      buf_q <= res;
    end else if (out_take) begin
      buf_q[0] <= buf_q[1];
      buf_q[1] <= buf_q[2];
    end
  end

endmodule

[rtl/lcpsb_checker.sv]
// Port-level checker for the LSB-first code packer with sub-block lengths.
// Depends on lcpsb_pkg; bound to lsb_first_code_packer_subblocks_unit below.
module lcpsb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        kind_o,
  input logic [7:0]  out_byte_o,
  input logic        last_o
);
  import lcpsb_pkg::*;

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat withdrawn while stalled");

  // A length beat that is not the last of its item closes a full sub-block.
  a_len_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_LEN) && !last_o |-> out_byte_o == SUB_LEN)
    else $error("non-final length beat is not a full sub-block");

  // No length beat ever exceeds the sub-block size.
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_LEN) |-> out_byte_o <= SUB_LEN)
    else $error("length beat exceeds sub-block size");

  // After a non-final beat is taken, the rest of that item's results follow.
  a_item_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("item results broken off before the last beat");

endmodule

bind lsb_first_code_packer_subblocks_unit lcpsb_checker u_lcpsb_checker (.*);

[dv/packed_stream_checker.sv]
// Checker for the LSB-first code packer: watches both channels, predicts the packed beats
// and compares every accepted result beat against the oldest prediction.
// Depends on lcpsb_pkg for the action and kind codes, the result record and the size limits.
module packed_stream_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        action_i,
  input  logic [15:0] code_value_i,
  input  logic [4:0]  code_bits_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        kind_i,
  input  logic [7:0]  out_byte_i,
  input  logic        last_i,
  input  logic        done_i,
  output int          fail_count_o,
  output int          pending_o
);
  import lcpsb_pkg::*;

  // Packing state mirrored from the block.
  logic [7:0] pack_partial;
  logic [2:0] pack_pending;
  logic [7:0] block_fill;

  // Result beats predicted but not yet seen on the output channel.
  result_t packed_q[$];
  result_t got_want;
  result_t tail_beat;
  bit      closed;

  // One line per mismatch, and count it.
  task automatic report_bad(input string what);
    $display("%0t packer mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  task automatic emit_beat(input kind_e k, input logic [7:0] b);
    packed_q.push_back('{kind: k, out_byte: b, last: 1'b0});
  endtask

  // A finished data byte, closing the sub-block when it becomes full.
  task automatic emit_data(input logic [7:0] b);
    emit_beat(KIND_DATA, b);
    block_fill = block_fill + 8'd1;
    if (block_fill >= SUB_LEN) begin
      emit_beat(KIND_LEN, SUB_LEN);
      block_fill = 8'd0;
    end
  endtask

  // Work out the beats that one accepted item causes.
  task automatic pack_item(input logic act, input logic [15:0] cv, input logic [4:0] cb);
    logic [4:0]  nbits;
    logic [23:0] acc;
    logic [5:0]  total;
    int          count_before;
    count_before = packed_q.size();
    if (act == ACT_APPEND) begin
      nbits = (cb > CODE_LIMIT) ? CODE_LIMIT : cb;
      acc = {16'h0000, pack_partial} |
            ((24'(cv) & ((24'h1 << nbits) - 24'h1)) << pack_pending);
      total = 6'(pack_pending) + 6'(nbits);
      while (total >= 6'd8) begin
        emit_data(acc[7:0]);
        acc = acc >> 8;
        total = total - 6'd8;
      end
      pack_partial = acc[7:0];
      pack_pending = total[2:0];
    end else begin
      // Flush: padded partial byte if any, then the final sub-block length.
      if (pack_pending != 3'd0) emit_data(pack_partial);
      emit_beat(KIND_LEN, block_fill);
      pack_partial = 8'd0;
      pack_pending = 3'd0;
      block_fill   = 8'd0;
    end
    // Mark the final beat of this item.
    if (packed_q.size() > count_before) begin
      tail_beat = packed_q.pop_back();
      tail_beat.last = 1'b1;
      packed_q.push_back(tail_beat);
    end
  endtask

  // Compare output beats first; a beat taken at this edge never belongs to an item
  // taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_partial = 8'd0;
      pack_pending = 3'd0;
      block_fill   = 8'd0;
      packed_q.delete();
      closed = 1'b0;
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (packed_q.size() == 0) begin
          report_bad($sformatf("result beat kind %b byte %h with none predicted",
                               kind_i, out_byte_i));
        end else begin
          got_want = packed_q.pop_front();
          if (kind_i !== got_want.kind)
            report_bad($sformatf("kind %b, predicted %b", kind_i, got_want.kind));
          if (out_byte_i !== got_want.out_byte)
            report_bad($sformatf("byte %h, predicted %h", out_byte_i, got_want.out_byte));
          if (last_i !== got_want.last)
            report_bad($sformatf("last %b, predicted %b", last_i, got_want.last));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pack_item(action_i, code_value_i, code_bits_i);
      end
      // Predictions still waiting when the run closes are failures.
      if (done_i && !closed) begin
        closed = 1'b1;
        if (packed_q.size() != 0)
          report_bad($sformatf("%0d predicted beats never arrived", packed_q.size()));
      end
      pending_o <= packed_q.size();
    end
  end

endmodule

[dv/tb_top.sv]
// Top of the testbench for the LSB-first code packer: clock, reset, stimulus and verdict.
// Depends on lcpsb_pkg, lsb_first_code_packer_subblocks_unit and packed_stream_checker.
module tb_top;
  import lcpsb_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        action_i;
  logic [15:0] code_value_i;
  logic [4:0]  code_bits_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        kind_o;
  logic [7:0]  out_byte_o;
  logic        last_o;

  logic        quiet;
  logic        done;
  int          fail_count;
  int          beats_waiting;
  int          idle_cycles;

  lsb_first_code_packer_subblocks_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .code_value_i(code_value_i),
    .code_bits_i (code_bits_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

  packed_stream_checker packer_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .action_i    (action_i),
    .code_value_i(code_value_i),
    .code_bits_i (code_bits_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_i      (kind_o),
    .out_byte_i  (out_byte_o),
    .last_i      (last_o),
    .done_i      (done),
    .fail_count_o(fail_count),
    .pending_o   (beats_waiting)
  );

  // Clock with a period of 10.
  always #5 clk_i = ~clk_i;

  // Receiver stalls at random unless the quiet stretch is on.
  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 19);
  end

  // Abort when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one item and hold it until the block takes the beat.
  task automatic send_item(input action_e act, input logic [15:0] cv, input logic [4:0] cb);
    while (!quiet && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    code_value_i <= cv;
    code_bits_i  <= cb;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Full-width codes with random content, two data bytes each.
  task automatic fill_words(input int n);
    repeat (n) send_item(ACT_APPEND, 16'($urandom_range(65535)), 5'd16);
  endtask

  initial begin
    int          sent;
    int          ep;
    int          r;
    logic [4:0]  bits;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    action_i     <= ACT_APPEND;
    code_value_i <= 16'h0000;
    code_bits_i  <= 5'd0;
    quiet        <= 1'b0;
    done         <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: flush on empty state gives only the zero terminator.
    send_item(ACT_FLUSH, 16'hFFFF, 5'd31);
    // Zero-length code, then full-width extremes.
    send_item(ACT_APPEND, 16'hFFFF, 5'd0);
    send_item(ACT_APPEND, 16'h0000, 5'd16);
    send_item(ACT_APPEND, 16'hFFFF, 5'd16);
    // Unaligned codes, oversized lengths that saturate, and bits above the length.
    send_item(ACT_APPEND, 16'h0005, 5'd3);
    send_item(ACT_APPEND, 16'hA5C3, 5'd16);
    send_item(ACT_APPEND, 16'h1234, 5'd31);
    send_item(ACT_APPEND, 16'hFFFF, 5'd17);
    send_item(ACT_APPEND, 16'h007F, 5'd7);
    send_item(ACT_APPEND, 16'hFFFE, 5'd1);
    send_item(ACT_FLUSH, 16'h0000, 5'd0);
    // A lone pending bit is padded out by the flush.
    send_item(ACT_APPEND, 16'h0001, 5'd1);
    send_item(ACT_FLUSH, 16'hFFFF, 5'd16);
    send_item(ACT_APPEND, 16'h00FF, 5'd8);
    send_item(ACT_APPEND, 16'h8000, 5'd16);
    send_item(ACT_FLUSH, 16'h5A5A, 5'd10);

    // Flush whose padded byte fills the sub-block: byte, full length, zero length.
    // The first half of the fill runs with no idling on either side.
    quiet <= 1'b1;
    fill_words(63);
    quiet <= 1'b0;
    fill_words(64);
    send_item(ACT_APPEND, 16'h0015, 5'd5);
    send_item(ACT_FLUSH, 16'hFFFF, 5'd31);

    // Short random episodes of codes, each closed by a flush.
    sent = 0;
    while (sent < 20) begin
      ep = $urandom_range(1, 8);
      repeat (ep) begin
        r = $urandom_range(99);
        if (r < 10) bits = 5'($urandom_range(17, 31));
        else if (r < 30) bits = 5'd16;
        else bits = 5'($urandom_range(0, 16));
        send_item(ACT_APPEND, 16'($urandom_range(65535)), bits);
        sent++;
      end
      send_item(ACT_FLUSH, 16'($urandom_range(65535)), 5'($urandom_range(31)));
      sent++;
    end
    in_valid_i <= 1'b0;
    quiet <= 1'b0;

    // Drain, let the block settle, then close the books.
    @(posedge clk_i);
    while (beats_waiting != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    done <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[lsb_first_code_packer_subblocks_unit.f]
rtl/lcpsb_pkg.sv
rtl/lsb_first_code_packer_subblocks_unit.sv
rtl/lcpsb_checker.sv
dv/packed_stream_checker.sv
dv/tb_top.sv
